// ===== rtl/bgu_pkg.sv =====
// Shared widths, codes, state encoding and divider handshake types of the grid upsampler.
package bgu_pkg;

   localparam int HEIGHT_W    = 24;
   localparam int COORD_W     = 7;
   localparam int INDEX_W     = 8;
   localparam int SPARSE_W    = 4;
   localparam int FULL_W      = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   // Largest sparse grid size honored; larger settings saturate to it. The sample
   // store holds one full sparse grid of this size.
   localparam int SPARSE_MAX = 15;

   // Largest fine grid size honored; larger settings saturate to it.
   localparam int FULL_MAX = 64;

   // Divider, blend weight and accumulator widths.
   localparam int DIV_W   = 40;
   localparam int QUO_W   = 24;
   localparam int STEP_W  = 5;
   localparam int WPROD_W = 14;
   localparam int HPROD_W = HEIGHT_W + WPROD_W + 1;
   localparam int ACC_W   = 40;

   localparam logic [STEP_W-1:0] AXIS_STEPS  = 5'd4;
   localparam logic [STEP_W-1:0] FINAL_STEPS = 5'd24;
   localparam int AXIS_SHIFT  = 3;
   localparam int FINAL_SHIFT = 24;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARSE_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_SIZE   = 1'b1;

   localparam logic [SPARSE_W-1:0] SPARSE_RESET = 4'd1;
   localparam logic [FULL_W-1:0]   FULL_RESET   = 7'd2;

   localparam logic [1:0] CORNER_NW = 2'd0;
   localparam logic [1:0] CORNER_NE = 2'd1;
   localparam logic [1:0] CORNER_SW = 2'd2;
   localparam logic [1:0] CORNER_SE = 2'd3;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_ROW   = 9'b000000010,
      ST_COL   = 9'b000000100,
      ST_FETCH = 9'b000001000,
      ST_HMUL  = 9'b000010000,
      ST_ACC   = 9'b000100000,
      ST_FIN   = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/bgu_ifs.sv =====
// Valid/ready channel interfaces for the request and response beats.
interface bgu_req_if import bgu_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [INDEX_W-1:0]         sample_index;
   logic signed [HEIGHT_W-1:0] sample_height;
   logic [COORD_W-1:0]         query_row;
   logic [COORD_W-1:0]         query_col;

   modport source (
      output valid, command, sample_index, sample_height, query_row, query_col,
      input  ready
   );
   modport sink (
      input  valid, command, sample_index, sample_height, query_row, query_col,
      output ready
   );
endinterface

interface bgu_rsp_if import bgu_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [HEIGHT_W-1:0] vertex_height;
   logic [COORD_W-1:0]         vertex_row;
   logic [COORD_W-1:0]         vertex_col;

   modport source (
      output valid, vertex_height, vertex_row, vertex_col,
      input  ready
   );
   modport sink (
      input  valid, vertex_height, vertex_row, vertex_col,
      output ready
   );
endinterface

// ===== rtl/bilinear_grid_upsampler_core.sv =====
// Top level of the bilinear grid upsampler: sequencer, blend datapath and result register.
//
//   channel   dir   handshake            payload
//   req_ch    in    valid / ready        command, sample_index, sample_height,
//                                        query_row, query_col
//   rsp_ch    out   valid / ready        vertex_height, vertex_row, vertex_col
//   csr_*     in    csr_wr_en, no wait   csr_index, csr_wdata
//
// A load beat leaves the block idle, so it is ready again on the next cycle.
// A query beat occupies the block until the shared divider has finished: two
// 4-step divisions map the row and the column onto the sparse grid, and a
// 24-step division scales and rounds the blend. The single memory read port
// adds one fetch per corner sample.
// Reset is synchronous and active high; it sets sparse_size to 1, full_size to 2
// and empties the result register. Sample memory is not cleared.
// A finished result waits in the result register; loads keep flowing while it
// waits, and a following query stalls only at its very end if the register is
// still full.
module bilinear_grid_upsampler_core import bgu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bgu_req_if.sink                req_ch,
   bgu_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int STORE_DEPTH  = (SPARSE_MAX + 1) * (SPARSE_MAX + 1);
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);

   // Configuration registers.
   logic [SPARSE_W-1:0] sparse_size_ff, sparse_size_in;
   logic [FULL_W-1:0]   full_size_ff, full_size_in;

   // Sequencer and per-query context.
   state_type            state_ff, state_in;
   logic [SPARSE_W-1:0]  s_ff, s_in;
   logic [FULL_W-1:0]    f_ff, f_in;
   logic [COORD_W-1:0]   r_ff, r_in;
   logic [COORD_W-1:0]   c_ff, c_in;
   logic [SPARSE_W-1:0]  v0_ff, v0_in;
   logic [SPARSE_W-1:0]  u0_ff, u0_in;
   logic [FULL_W-1:0]    wv_ff, wv_in;
   logic [FULL_W-1:0]    wu_ff, wu_in;
   logic [1:0]           corner_ff, corner_in;
   logic [WPROD_W-1:0]   den_ff, den_in;
   logic [WPROD_W-1:0]   wp_ff, wp_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [HEIGHT_W-1:0] vertex_height_ff, vertex_height_in;
   logic [COORD_W-1:0]         vertex_row_ff, vertex_row_in;
   logic [COORD_W-1:0]         vertex_col_ff, vertex_col_in;

   // Combinational helpers.
   logic                       accept;
   logic                       rsp_free;
   logic [SPARSE_W-1:0]        s_eff;
   logic [FULL_W-1:0]          f_eff;
   logic [COORD_W-1:0]         r_eff;
   logic [COORD_W-1:0]         c_eff;
   logic [COORD_W-1:0]         axis_coord;
   logic [SPARSE_W-1:0]        axis_s;
   logic [FULL_W-1:0]          axis_f;
   logic [COORD_W+SPARSE_W-1:0] axis_prod;
   logic [SPARSE_W-1:0]        q_raw;
   logic [FULL_W-1:0]          q_rem;
   logic [SPARSE_W-1:0]        cell_idx;
   logic [FULL_W-1:0]          weight;
   logic [FULL_W-1:0]          col_factor;
   logic [FULL_W-1:0]          row_factor;
   logic [SPARSE_W:0]          edge_len;
   logic [INDEX_W-1:0]         corner_offset;
   logic [INDEX_W-1:0]         rd_addr8;
   logic signed [HPROD_W-1:0]  hw_prod;
   logic                       load_hit;
   div_req_type                div_req;
   div_rsp_type                div_rsp;
   logic signed [HEIGHT_W-1:0] sample_rd;

   // ---------------------------------------------------------------------------------
   // Configuration writes; an index past the list is ignored by the decode.
   // ---------------------------------------------------------------------------------
   always_comb begin
      sparse_size_in = sparse_size_ff;
      full_size_in   = full_size_ff;
      if (csr_wr_en && (csr_index == CSR_SPARSE_SIZE)) begin
         sparse_size_in = csr_wdata[SPARSE_W-1:0];
      end
      if (csr_wr_en && (csr_index == CSR_FULL_SIZE)) begin
         full_size_in = csr_wdata[FULL_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------------
   // Effective sizes: zero counts as one and large values saturate. Query coordinates
   // saturate to the effective fine size, and the saturated values are echoed.
   // ---------------------------------------------------------------------------------
   always_comb begin
      if (sparse_size_ff == '0) begin
         s_eff = SPARSE_W'(1);
      end else if (32'(sparse_size_ff) > SPARSE_MAX) begin
         s_eff = SPARSE_W'(SPARSE_MAX);
      end else begin
         s_eff = sparse_size_ff;
      end
      if (full_size_ff == '0) begin
         f_eff = FULL_W'(1);
      end else if (32'(full_size_ff) > FULL_MAX) begin
         f_eff = FULL_W'(FULL_MAX);
      end else begin
         f_eff = full_size_ff;
      end
      r_eff = (req_ch.query_row > f_eff) ? f_eff : req_ch.query_row;
      c_eff = (req_ch.query_col > f_eff) ? f_eff : req_ch.query_col;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // A load beyond the store is dropped.
   assign load_hit = accept && (req_ch.command == CMD_LOAD) &&
                     (32'(req_ch.sample_index) < STORE_DEPTH);

   // ---------------------------------------------------------------------------------
   // Axis mapping. The row division starts straight from the accepted beat; the column
   // division starts from the stored context when the row result comes back.
   // ---------------------------------------------------------------------------------
   always_comb begin
      if (state_ff == ST_IDLE) begin
         axis_coord = r_eff;
         axis_s     = s_eff;
         axis_f     = f_eff;
      end else begin
         axis_coord = c_ff;
         axis_s     = s_ff;
         axis_f     = f_ff;
      end
      axis_prod = {{SPARSE_W{1'b0}}, axis_coord} * {{COORD_W{1'b0}}, axis_s};
   end

   // The quotient never exceeds the sparse size. When it equals it, the vertex lies on
   // the far edge: the cell steps back by one and the weight becomes the full cell.
   always_comb begin
      q_raw = div_rsp.quotient[SPARSE_W-1:0];
      q_rem = div_rsp.remainder[FULL_W-1:0];
      if (q_raw == s_ff) begin
         cell_idx = s_ff - 1'b1;
         weight   = FULL_W'({1'b0, q_rem} + {1'b0, f_ff});
      end else begin
         cell_idx = q_raw;
         weight   = q_rem;
      end
   end

   // ---------------------------------------------------------------------------------
   // Corner selection: address offset into the row-major store and the two weight
   // factors that scale this corner's sample.
   // ---------------------------------------------------------------------------------
   always_comb begin
      edge_len = {1'b0, s_ff} + 1'b1;
      case (corner_ff)
         CORNER_NW: begin
            corner_offset = '0;
            col_factor    = f_ff - wu_ff;
            row_factor    = f_ff - wv_ff;
         end
         CORNER_NE: begin
            corner_offset = INDEX_W'(1);
            col_factor    = wu_ff;
            row_factor    = f_ff - wv_ff;
         end
         CORNER_SW: begin
            corner_offset = INDEX_W'(edge_len);
            col_factor    = f_ff - wu_ff;
            row_factor    = wv_ff;
         end
         CORNER_SE: begin
            corner_offset = INDEX_W'(edge_len) + 1'b1;
            col_factor    = wu_ff;
            row_factor    = wv_ff;
         end
         default: begin
            corner_offset = '0;
            col_factor    = '0;
            row_factor    = '0;
         end
      endcase
      rd_addr8 = INDEX_W'({{(INDEX_W-SPARSE_W){1'b0}}, v0_ff} *
                          {{(INDEX_W-SPARSE_W-1){1'b0}}, edge_len})
               + INDEX_W'(u0_ff) + corner_offset;
   end

   assign hw_prod = sample_rd * $signed({1'b0, wp_ff});

   // ---------------------------------------------------------------------------------
   // Sequencer and datapath.
   // The accumulator starts at den << 23 so that the final dividend 2*acc + den is
   // never negative; the quotient then carries the result offset by 2^23, which is
   // removed by flipping its top bit.
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      s_in             = s_ff;
      f_in             = f_ff;
      r_in             = r_ff;
      c_in             = c_ff;
      v0_in            = v0_ff;
      u0_in            = u0_ff;
      wv_in            = wv_ff;
      wu_in            = wu_ff;
      corner_in        = corner_ff;
      den_in           = den_ff;
      wp_in            = wp_ff;
      prod_in          = prod_ff;
      acc_in           = acc_ff;
      rsp_valid_in     = rsp_valid_ff;
      vertex_height_in = vertex_height_ff;
      vertex_row_in    = vertex_row_ff;
      vertex_col_in    = vertex_col_ff;

      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(axis_prod);
      div_req.divisor  = DIV_W'(axis_f) << AXIS_SHIFT;
      div_req.steps    = AXIS_STEPS;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_ch.command == CMD_QUERY)) begin
               s_in          = s_eff;
               f_in          = f_eff;
               r_in          = r_eff;
               c_in          = c_eff;
               div_req.start = 1'b1;
               state_in      = ST_ROW;
            end
         end
         ST_ROW: begin
            den_in = {{FULL_W{1'b0}}, f_ff} * {{FULL_W{1'b0}}, f_ff};
            if (div_rsp.done) begin
               v0_in         = cell_idx;
               wv_in         = weight;
               div_req.start = 1'b1;
               state_in      = ST_COL;
            end
         end
         ST_COL: begin
            if (div_rsp.done) begin
               u0_in     = cell_idx;
               wu_in     = weight;
               corner_in = CORNER_NW;
               acc_in    = ACC_W'(den_ff) << (FINAL_SHIFT - 1);
               state_in  = ST_FETCH;
            end
         end
         ST_FETCH: begin
            wp_in    = {{FULL_W{1'b0}}, col_factor} * {{FULL_W{1'b0}}, row_factor};
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            prod_in  = ACC_W'(hw_prod);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + prod_ff;
            if (corner_ff == CORNER_SE) begin
               state_in = ST_FIN;
            end else begin
               corner_in = corner_ff + 1'b1;
               state_in  = ST_FETCH;
            end
         end
         ST_FIN: begin
            div_req.start    = 1'b1;
            div_req.dividend = {acc_ff[ACC_W-2:0], 1'b0} + DIV_W'(den_ff);
            div_req.divisor  = DIV_W'(den_ff) << FINAL_SHIFT;
            div_req.steps    = FINAL_STEPS;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               vertex_height_in = {~div_rsp.quotient[QUO_W-1], div_rsp.quotient[QUO_W-2:0]};
               vertex_row_in    = r_ff;
               vertex_col_in    = c_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sparse_size_ff <= SPARSE_RESET;
         full_size_ff   <= FULL_RESET;
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sparse_size_ff <= sparse_size_in;
         full_size_ff   <= full_size_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s_ff             <= s_in;
      f_ff             <= f_in;
      r_ff             <= r_in;
      c_ff             <= c_in;
      v0_ff            <= v0_in;
      u0_ff            <= u0_in;
      wv_ff            <= wv_in;
      wu_ff            <= wu_in;
      corner_ff        <= corner_in;
      den_ff           <= den_in;
      wp_ff            <= wp_in;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      vertex_height_ff <= vertex_height_in;
      vertex_row_ff    <= vertex_row_in;
      vertex_col_ff    <= vertex_col_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.vertex_height = vertex_height_ff;
   assign rsp_ch.vertex_row    = vertex_row_ff;
   assign rsp_ch.vertex_col    = vertex_col_ff;

   // ---------------------------------------------------------------------------------
   // Shared divider and sample memory.
   // ---------------------------------------------------------------------------------
   bgu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bgu_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (STORE_ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_hit),
      .wr_addr (STORE_ADDR_W'(req_ch.sample_index)),
      .wr_data (req_ch.sample_height),
      .rd_addr (STORE_ADDR_W'(rd_addr8)),
      .rd_data (sample_rd)
   );

endmodule

// ===== rtl/bgu_div.sv =====
// Shared restoring divider: one compare and subtract per cycle.
module bgu_div import bgu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              running_ff, running_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              fits;

   // The divisor arrives pre-shifted so that the first step tests the top quotient bit.
   always_comb begin
      fits       = (rem_ff >= dvs_ff);
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         running_in = 1'b1;
         cnt_in     = div_req.steps;
         rem_in     = div_req.dividend;
         dvs_in     = div_req.divisor;
         quo_in     = '0;
      end else if (running_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== rtl/bgu_store.sv =====
// Sample memory: one write port and one registered read port.
module bgu_store import bgu_pkg::*; #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic signed [HEIGHT_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic signed [HEIGHT_W-1:0] rd_data
);

   logic signed [HEIGHT_W-1:0] mem_ff [DEPTH];
   logic signed [HEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/bgu_blend_monitor.sv =====
`timescale 1ns / 100ps
// Watches the request, response and register ports, predicts each vertex and compares it.
module bgu_blend_monitor import bgu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bgu_req_if                     req_mon,
   bgu_rsp_if                     rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic [COORD_W-1:0]         row;
      logic [COORD_W-1:0]         col;
   } vertex_type;

   logic signed [HEIGHT_W-1:0] heights [256];
   logic [SPARSE_W-1:0]        sparse_size;
   logic [FULL_W-1:0]          full_size;
   vertex_type                 vertex_queue [$];

   // Cell index and remainder weight, in units of 1/fine, of one fine coordinate.
   function automatic void map_axis(input int coord, input int cells, input int fine,
                                    output int cell_idx, output longint weight);
      int prod;
      prod     = coord * cells;
      cell_idx = prod / fine;
      if (cell_idx > cells - 1)
         cell_idx = cells - 1;
      weight = prod - cell_idx * fine;
   endfunction

   function automatic vertex_type blend_vertex(input logic [COORD_W-1:0] row_in,
                                               input logic [COORD_W-1:0] col_in);
      int         s, f, r, c, v0, u0, e;
      longint     wv, wu, fl, h00, h01, h10, h11, num, den, quo;
      vertex_type v;
      s = (sparse_size == 0) ? 1 : int'(sparse_size);
      f = (full_size == 0) ? 1 : int'(full_size);
      if (f > FULL_MAX)
         f = FULL_MAX;
      r = int'(row_in);
      c = int'(col_in);
      if (r > f)
         r = f;
      if (c > f)
         c = f;
      map_axis(r, s, f, v0, wv);
      map_axis(c, s, f, u0, wu);
      e   = s + 1;
      h00 = heights[v0 * e + u0];
      h01 = heights[v0 * e + u0 + 1];
      h10 = heights[(v0 + 1) * e + u0];
      h11 = heights[(v0 + 1) * e + u0 + 1];
      fl  = f;
      num = h00 * (fl - wu) * (fl - wv) + h01 * wu * (fl - wv)
          + h10 * (fl - wu) * wv + h11 * wu * wv;
      den = fl * fl;
      // Round to nearest with ties upward: floor((2*num + den) / (2*den)).
      num = 2 * num + den;
      den = 2 * den;
      quo = num / den;
      if ((num % den) != 0 && num < 0)
         quo = quo - 1;
      v.height = quo[HEIGHT_W-1:0];
      v.row    = r[COORD_W-1:0];
      v.col    = c[COORD_W-1:0];
      return v;
   endfunction

   always @(posedge clock) begin : watch
      vertex_type expected;
      if (reset) begin
         sparse_size = SPARSE_RESET;
         full_size   = FULL_RESET;
         vertex_queue.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_SPARSE_SIZE)
               sparse_size = csr_wdata[SPARSE_W-1:0];
            else if (csr_index == CSR_FULL_SIZE)
               full_size = csr_wdata[FULL_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.command == CMD_LOAD)
               heights[req_mon.sample_index] = req_mon.sample_height;
            else
               vertex_queue.push_back(blend_vertex(req_mon.query_row, req_mon.query_col));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (vertex_queue.size() == 0) begin
               $error("vertex beat with no query waiting: height %0d row %0d col %0d",
                      rsp_mon.vertex_height, rsp_mon.vertex_row, rsp_mon.vertex_col);
               fail_count++;
            end else begin
               expected = vertex_queue.pop_front();
               if (rsp_mon.vertex_height !== expected.height) begin
                  $error("vertex_height: expected %0d, got %0d",
                         expected.height, rsp_mon.vertex_height);
                  fail_count++;
               end
               if (rsp_mon.vertex_row !== expected.row) begin
                  $error("vertex_row: expected %0d, got %0d", expected.row, rsp_mon.vertex_row);
                  fail_count++;
               end
               if (rsp_mon.vertex_col !== expected.col) begin
                  $error("vertex_col: expected %0d, got %0d", expected.col, rsp_mon.vertex_col);
                  fail_count++;
               end
            end
         end
      end
      pending_count = vertex_queue.size();
   end

endmodule

// ===== tb/sv/tb_bilinear_grid_upsampler_core.sv =====
`timescale 1ns / 100ps
// Top of the grid upsampler testbench: clock, reset, stimulus, response pacing and verdict.
module tb_bilinear_grid_upsampler_core;
   import bgu_pkg::*;

   // Margin that covers the whole run of one query through the block.
   localparam int SETTLE_CYCLES   = 64;
   // Long enough for one finished vertex to park and a second query to back up.
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_COUNT     = 12;
   localparam int PHASE_BEATS     = 70;
   localparam int HOLD_PHASE      = 3;

   localparam logic [HEIGHT_W-1:0] HEIGHT_TOP    = 24'h7FFFFF;
   localparam logic [HEIGHT_W-1:0] HEIGHT_BOTTOM = 24'h800000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending_count;

   // Stimulus-side view of the configuration, after the block's own clamping.
   int eff_sparse;
   int eff_full;

   // Once set, neither side inserts idle cycles any more.
   bit calm = 1'b0;
   // Each request for a long response hold-off bumps the first counter; the
   // response process bumps the second once it has served it.
   int hold_offs_asked = 0;
   int hold_offs_done  = 0;

   bgu_req_if req_ch ();
   bgu_rsp_if rsp_ch ();

   bilinear_grid_upsampler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bgu_blend_monitor blend_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   // Heights lean toward the two extremes and toward small values, so that the
   // rounding near zero and the full-range products are both exercised.
   function automatic logic [HEIGHT_W-1:0] pick_height();
      case ($urandom_range(0, 3))
         0: return HEIGHT_TOP;
         1: return HEIGHT_BOTTOM;
         2: return HEIGHT_W'($urandom_range(0, 2000) - 1000);
         default: return HEIGHT_W'($urandom);
      endcase
   endfunction

   // Mostly coordinates on the fine grid; now and then anything the field can
   // hold, which the block has to saturate.
   function automatic logic [COORD_W-1:0] pick_coord();
      if ($urandom_range(0, 9) == 0)
         return COORD_W'($urandom);
      return COORD_W'($urandom_range(0, eff_full));
   endfunction

   // Offers one request beat and returns at the edge where it is accepted.
   // Inputs change only at falling edges; a random idle burst may come first.
   task automatic send_beat(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input logic [HEIGHT_W-1:0] hgt,
                            input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
      @(negedge clock);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.sample_index  <= idx;
      req_ch.sample_height <= hgt;
      req_ch.query_row     <= row;
      req_ch.query_col     <= col;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Loads carry random query fields and queries random load fields, since the
   // block must ignore whichever part does not belong to the command.
   task automatic load_sample(input logic [INDEX_W-1:0] idx, input logic [HEIGHT_W-1:0] hgt);
      send_beat(CMD_LOAD, idx, hgt, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic query_vertex(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
      send_beat(CMD_QUERY, INDEX_W'($urandom), HEIGHT_W'($urandom), row, col);
   endtask

   // Stops offering beats until every predicted vertex has come back, then
   // leaves room for a load that may still be in flight.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Reprograms both sizes once the block is idle. The sparse size register
   // takes only the low bits of the data, so the rest is filled with noise.
   task automatic set_grid(input int sparse_val, input int full_val);
      wait_idle();
      write_csr(CSR_SPARSE_SIZE, {3'($urandom), sparse_val[SPARSE_W-1:0]});
      write_csr(CSR_FULL_SIZE, full_val[FULL_W-1:0]);
      eff_sparse = (sparse_val == 0) ? 1 : sparse_val;
      eff_full   = (full_val == 0) ? 1 : ((full_val > FULL_MAX) ? FULL_MAX : full_val);
   endtask

   // Response side: random stall bursts, one long hold-off on request, and a
   // steady ready once the run turns calm.
   initial begin : response_pacing
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_offs_done != hold_offs_asked) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_offs_done++;
            rsp_ch.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int sparse_val;
      int full_val;

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.command       = CMD_LOAD;
      req_ch.sample_index  = '0;
      req_ch.sample_height = '0;
      req_ch.query_row     = '0;
      req_ch.query_col     = '0;
      eff_sparse           = int'(SPARSE_RESET);
      eff_full             = int'(FULL_RESET);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset sizes give one 2x2 cell. A checkerboard of the two extremes
      // covers the corners, the edge midpoints and the center, where the
      // blend lands exactly halfway and must round upward to zero.
      load_sample(0, HEIGHT_TOP);
      load_sample(1, HEIGHT_BOTTOM);
      load_sample(2, HEIGHT_BOTTOM);
      load_sample(3, HEIGHT_TOP);
      query_vertex(0, 0);
      query_vertex(0, 2);
      query_vertex(2, 2);
      query_vertex(1, 1);
      query_vertex(1, 0);
      // Coordinates past the fine grid saturate onto its south-east edge.
      query_vertex(127, 127);
      query_vertex(127, 0);
      // Uniform extremes must come back unchanged.
      for (int i = 0; i < 4; i++)
         load_sample(INDEX_W'(i), HEIGHT_TOP);
      query_vertex(1, 1);
      for (int i = 0; i < 4; i++)
         load_sample(INDEX_W'(i), HEIGHT_BOTTOM);
      query_vertex(1, 2);

      // Write every entry of the store once, so that no later query can read
      // a location that was never loaded.
      for (int i = 0; i < 256; i++)
         load_sample(INDEX_W'(i), HEIGHT_W'($urandom));

      // Zero sizes act as one.
      set_grid(0, 0);
      query_vertex(0, 0);
      query_vertex(1, 1);
      query_vertex(5, 3);
      // Largest sparse grid, and a fine size beyond the maximum that saturates.
      set_grid(15, 127);
      query_vertex(64, 64);
      query_vertex(127, 0);
      query_vertex(63, 1);
      // Fine grid coarser than the sparse one.
      set_grid(15, 2);
      query_vertex(1, 1);
      query_vertex(2, 2);

      // Random phases, each under its own grid setting. Small grids are
      // reloaded first so that their corners carry fresh patterns; then
      // queries dominate, with stray loads anywhere in the store.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin sparse_val = 15; full_val = 64; end
            1: begin sparse_val = 1;  full_val = 2;  end
            2: begin sparse_val = 4;  full_val = 16; end
            3: begin sparse_val = 7;  full_val = 45; end
            4: begin sparse_val = 3;  full_val = 7;  end
            5: begin sparse_val = 15; full_val = 16; end
            6: begin sparse_val = 2;  full_val = 64; end
            7: begin sparse_val = 9;  full_val = 100; end
            default: begin
               sparse_val = $urandom_range(0, 15);
               full_val   = $urandom_range(0, 127);
            end
         endcase
         // The last phase runs without idle cycles on either side.
         if (p == PHASE_COUNT - 1)
            calm = 1'b1;
         set_grid(sparse_val, full_val);
         if (eff_sparse <= 4) begin
            for (int i = 0; i < (eff_sparse + 1) * (eff_sparse + 1); i++)
               load_sample(INDEX_W'(i), pick_height());
         end
         // Starve the response side for a while; the queries keep coming, so
         // the result register fills and the request side backs up.
         if (p == HOLD_PHASE)
            hold_offs_asked++;
         repeat (PHASE_BEATS) begin
            if ($urandom_range(0, 9) < 7)
               query_vertex(pick_coord(), pick_coord());
            else
               load_sample(INDEX_W'($urandom), pick_height());
         end
      end

      wait_idle();
      if (fail_count == 0)
         $display("tb_bilinear_grid_upsampler_core: PASS");
      else
         $display("tb_bilinear_grid_upsampler_core: FAIL");
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin : watchdog
      #2000000;
      $display("tb_bilinear_grid_upsampler_core: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bgu_pkg.sv
rtl/bgu_ifs.sv
rtl/bgu_div.sv
rtl/bgu_store.sv
rtl/bilinear_grid_upsampler_core.sv
tb/sv/bgu_blend_monitor.sv
tb/sv/tb_bilinear_grid_upsampler_core.sv
